@@ hdl/gct_pkg.sv @@
// gct_pkg: shared types, codes and sizes of the grow-only counter table
// used by gct_front, gct_back and grow_only_counter_table_core
package gct_pkg;

  // table size default and its allowed range is 1 to 64
  localparam int unsigned MAX_ENTRIES_DEF = 16;

  // depth of the command queue between front and back
  localparam int unsigned CMD_DEPTH = 4;

  localparam int unsigned ID_W  = 16;
  localparam int unsigned CNT_W = 64;

  // command codes as they arrive on the cmd field
  typedef enum logic [1:0] {
    OP_INC   = 2'd0,
    OP_MERGE = 2'd1,
    OP_SNAP  = 2'd2,
    OP_DELTA = 2'd3
  } op_e;

  // sequencer states of the back end
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INC,
    ST_MRG0,
    ST_RD,
    ST_CMP,
    ST_UPD,
    ST_APPEND,
    ST_SUM,
    ST_RESULT,
    ST_SNAP0,
    ST_SNAP_RD,
    ST_SNAP_EMIT,
    ST_DELTA
  } st_e;

  // classified command handed from front to back
  typedef struct packed {
    op_e              op;
    logic [ID_W-1:0]  nid;
    logic [CNT_W-1:0] amt;
    logic             amt_nz;
  } cmd_t;

  // one result item
  typedef struct packed {
    logic [ID_W-1:0]  node;
    logic [CNT_W-1:0] count;
    logic             valid;
    logic             last;
    logic             changed;
    logic             full;
    logic [CNT_W-1:0] total;
    logic [CNT_W-1:0] local_total;
  } res_t;

  // queue handshake between front and back
  typedef struct packed {
    logic avail;
  } q_stat_t;

endpackage

@@ hdl/gct_ram.sv @@
// gct_ram: generic single write port, single read port RAM with registered read
// no dependencies
module gct_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ hdl/gct_front.sv @@
// gct_front: accepts input items, classifies them and queues them for the back end
// depends on gct_pkg
module gct_front #(
  parameter int unsigned DEPTH = gct_pkg::CMD_DEPTH
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                cmd_i,
  input  logic [gct_pkg::ID_W-1:0]  node_id_i,
  input  logic [gct_pkg::CNT_W-1:0] amount_i,
  output gct_pkg::cmd_t             cmd_o,
  output gct_pkg::q_stat_t          stat_o,
  input  logic                      take_i
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  gct_pkg::cmd_t mem_q [DEPTH];
  gct_pkg::cmd_t cls;
  logic [PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          do_push, do_pop;

  // classify the incoming item
  always_comb begin
    cls.op     = gct_pkg::op_e'(cmd_i);
    cls.nid    = node_id_i;
    cls.amt    = amount_i;
    cls.amt_nz = (amount_i != '0);
  end

  assign full         = (cnt_q == CW'(DEPTH));
  assign stat_o.avail = (cnt_q != '0);
  assign do_push      = push && !full;
  assign do_pop       = take_i && stat_o.avail;
  assign cmd_o        = mem_q[rd_ptr_q];

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

@@ hdl/gct_back.sv @@
// gct_back: table storage and sequencer that carries out queued commands
// depends on gct_pkg and gct_ram
module gct_back #(
  parameter int unsigned MAX_ENTRIES = gct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [gct_pkg::ID_W-1:0] cfg_data_i,
  input  gct_pkg::cmd_t            cmd_i,
  input  gct_pkg::q_stat_t         stat_i,
  output logic                     take_o,
  output gct_pkg::res_t            res_o,
  output logic                     res_valid_o,
  input  logic                     pop_i
);

  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned USE_W = $clog2(MAX_ENTRIES + 1);

  gct_pkg::st_e  state_q, state_d;
  gct_pkg::cmd_t cmd_q, cmd_d;
  gct_pkg::res_t res_q, res_d;
  logic          res_valid_q;
  logic          emit, out_free;

  logic [gct_pkg::ID_W-1:0]  local_id_q;
  logic [IDX_W-1:0]          idx_q, idx_d;
  logic [USE_W-1:0]          used_q, used_d;
  logic                      dirty_q, dirty_d;
  logic [gct_pkg::CNT_W-1:0] sum_q, sum_d;
  logic [gct_pkg::CNT_W-1:0] lcnt_q, lcnt_d;
  logic [gct_pkg::CNT_W-1:0] cur_q, cur_d;
  logic [gct_pkg::CNT_W-1:0] diff_q, diff_d;
  logic                      changed_q, changed_d;
  logic                      full_q, full_d;

  logic                      id_we, cnt_we;
  logic [IDX_W-1:0]          waddr;
  logic [gct_pkg::ID_W-1:0]  id_rdata;
  logic [gct_pkg::CNT_W-1:0] cnt_rdata;
  logic                      idx_is_last;

  // remote slots; slot zero lives in local_id_q and lcnt_q
  gct_ram #(
    .WIDTH(gct_pkg::ID_W),
    .DEPTH(MAX_ENTRIES)
  ) u_id_ram (
    .clk_i  (clk_i),
    .we_i   (id_we),
    .waddr_i(waddr),
    .wdata_i(cmd_q.nid),
    .raddr_i(idx_q),
    .rdata_o(id_rdata)
  );

  gct_ram #(
    .WIDTH(gct_pkg::CNT_W),
    .DEPTH(MAX_ENTRIES)
  ) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(waddr),
    .wdata_i(cmd_q.amt),
    .raddr_i(idx_q),
    .rdata_o(cnt_rdata)
  );

  assign out_free    = !res_valid_q || pop_i;
  assign idx_is_last = ((USE_W'(idx_q) + 1'b1) == used_q);
  assign res_o       = res_q;
  assign res_valid_o = res_valid_q;

  // sequencer next state and datapath
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    used_d    = used_q;
    dirty_d   = dirty_q;
    sum_d     = sum_q;
    lcnt_d    = lcnt_q;
    cur_d     = cur_q;
    diff_d    = diff_q;
    changed_d = changed_q;
    full_d    = full_q;
    take_o    = 1'b0;
    id_we     = 1'b0;
    cnt_we    = 1'b0;
    waddr     = idx_q;
    emit      = 1'b0;
    res_d             = '0;
    res_d.total       = sum_q;
    res_d.local_total = lcnt_q;

    unique case (state_q)
      gct_pkg::ST_IDLE: begin
        if (stat_i.avail) begin
          take_o    = 1'b1;
          cmd_d     = cmd_i;
          changed_d = 1'b0;
          full_d    = 1'b0;
          diff_d    = '0;
          unique case (cmd_i.op)
            gct_pkg::OP_INC:   state_d = gct_pkg::ST_INC;
            gct_pkg::OP_MERGE: state_d = gct_pkg::ST_MRG0;
            gct_pkg::OP_SNAP:  state_d = gct_pkg::ST_SNAP0;
            gct_pkg::OP_DELTA: state_d = gct_pkg::ST_DELTA;
            default:           state_d = gct_pkg::ST_IDLE;
          endcase
        end
      end
      // local increment
      gct_pkg::ST_INC: begin
        lcnt_d    = lcnt_q + cmd_q.amt;
        sum_d     = sum_q + cmd_q.amt;
        dirty_d   = 1'b1;
        changed_d = cmd_q.amt_nz;
        state_d   = gct_pkg::ST_RESULT;
      end
      // merge: slot zero is searched first
      gct_pkg::ST_MRG0: begin
        if (cmd_q.nid == local_id_q) begin
          idx_d   = '0;
          cur_d   = lcnt_q;
          state_d = gct_pkg::ST_UPD;
        end else if (used_q > USE_W'(1)) begin
          idx_d   = IDX_W'(1);
          state_d = gct_pkg::ST_RD;
        end else begin
          state_d = gct_pkg::ST_APPEND;
        end
      end
      gct_pkg::ST_RD: begin
        state_d = gct_pkg::ST_CMP;
      end
      gct_pkg::ST_CMP: begin
        if (id_rdata == cmd_q.nid) begin
          cur_d   = cnt_rdata;
          state_d = gct_pkg::ST_UPD;
        end else if (!idx_is_last) begin
          idx_d   = idx_q + 1'b1;
          state_d = gct_pkg::ST_RD;
        end else begin
          state_d = gct_pkg::ST_APPEND;
        end
      end
      // keep the larger count
      gct_pkg::ST_UPD: begin
        if (cmd_q.amt > cur_q) begin
          diff_d    = cmd_q.amt - cur_q;
          changed_d = 1'b1;
          if (idx_q == '0) begin
            lcnt_d = cmd_q.amt;
          end else begin
            cnt_we = 1'b1;
          end
        end
        state_d = gct_pkg::ST_SUM;
      end
      // unknown id: append or flag a full table
      gct_pkg::ST_APPEND: begin
        if (used_q < USE_W'(MAX_ENTRIES)) begin
          waddr     = used_q[IDX_W-1:0];
          id_we     = 1'b1;
          cnt_we    = 1'b1;
          used_d    = used_q + 1'b1;
          diff_d    = cmd_q.amt;
          changed_d = 1'b1;
          state_d   = gct_pkg::ST_SUM;
        end else begin
          full_d  = 1'b1;
          state_d = gct_pkg::ST_RESULT;
        end
      end
      gct_pkg::ST_SUM: begin
        sum_d   = sum_q + diff_q;
        state_d = gct_pkg::ST_RESULT;
      end
      // single status result for increment and merge
      gct_pkg::ST_RESULT: begin
        if (out_free) begin
          emit          = 1'b1;
          res_d.last    = 1'b1;
          res_d.changed = changed_q;
          res_d.full    = full_q;
          state_d       = gct_pkg::ST_IDLE;
        end
      end
      // snapshot walks the used slots in order
      gct_pkg::ST_SNAP0: begin
        if (out_free) begin
          emit        = 1'b1;
          res_d.node  = local_id_q;
          res_d.count = lcnt_q;
          res_d.valid = 1'b1;
          res_d.last  = (used_q == USE_W'(1));
          if (used_q == USE_W'(1)) begin
            state_d = gct_pkg::ST_IDLE;
          end else begin
            idx_d   = IDX_W'(1);
            state_d = gct_pkg::ST_SNAP_RD;
          end
        end
      end
      gct_pkg::ST_SNAP_RD: begin
        state_d = gct_pkg::ST_SNAP_EMIT;
      end
      gct_pkg::ST_SNAP_EMIT: begin
        if (out_free) begin
          emit        = 1'b1;
          res_d.node  = id_rdata;
          res_d.count = cnt_rdata;
          res_d.valid = 1'b1;
          res_d.last  = idx_is_last;
          if (idx_is_last) begin
            state_d = gct_pkg::ST_IDLE;
          end else begin
            idx_d   = idx_q + 1'b1;
            state_d = gct_pkg::ST_SNAP_RD;
          end
        end
      end
      // delta: local entry once per dirty period
      gct_pkg::ST_DELTA: begin
        if (out_free) begin
          emit       = 1'b1;
          res_d.last = 1'b1;
          if (dirty_q) begin
            res_d.node  = local_id_q;
            res_d.count = lcnt_q;
            res_d.valid = 1'b1;
          end
          dirty_d = 1'b0;
          state_d = gct_pkg::ST_IDLE;
        end
      end
      default: state_d = gct_pkg::ST_IDLE;
    endcase
  end

  // control and table state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gct_pkg::ST_IDLE;
      local_id_q  <= '0;
      used_q      <= USE_W'(1);
      dirty_q     <= 1'b0;
      sum_q       <= '0;
      lcnt_q      <= '0;
      idx_q       <= '0;
      changed_q   <= 1'b0;
      full_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      used_q    <= used_d;
      dirty_q   <= dirty_d;
      sum_q     <= sum_d;
      lcnt_q    <= lcnt_d;
      idx_q     <= idx_d;
      changed_q <= changed_d;
      full_q    <= full_d;
      if (cfg_we_i) begin
        local_id_q <= cfg_data_i;
      end
      if (emit) begin
        res_valid_q <= 1'b1;
      end else if (pop_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    cmd_q  <= cmd_d;
    cur_q  <= cur_d;
    diff_q <= diff_d;
    if (emit) begin
      res_q <= res_d;
    end
  end

endmodule

@@ hdl/grow_only_counter_table_core.sv @@
// grow_only_counter_table_core: top level of the grow-only counter table
// depends on gct_pkg, gct_front, gct_back and gct_ram
//
// Usage:
// - Input queue: drive cmd_i, node_id_i, amount_i with push; a transfer takes
//   place on a clock edge with push high and full low. Commands wait in a
//   four deep queue, so the sender is held off only when that queue fills.
// - Result queue: while empty is low the oldest result sits on the result
//   ports; pop high at a clock edge takes it. A stalled receiver freezes the
//   sequencer at its next result while the input queue keeps filling.
// - Configuration: cfg_valid_i/cfg_data_i set the local node id; cfg_ready_o
//   is always high. Write it only while no command is in flight.
// - Steps per command, from the idle state that picks it up: increment ST_INC,
//   ST_RESULT; snapshot emits slot zero, then ST_SNAP_RD, ST_SNAP_EMIT per
//   further slot; delta ST_DELTA; merge ST_MRG0, ST_RD and ST_CMP per remote
//   slot searched (the id search reads one table slot at a time through the RAM
//   read port), ST_UPD or ST_APPEND, ST_SUM unless the table is full, ST_RESULT.
// - Reset: the table holds only the local entry with count zero, the total is
//   zero, the dirty mark is clear and both queues are empty. No clearing pass
//   is needed; slots beyond the fill count are never read.
module grow_only_counter_table_core #(
  parameter int unsigned MAX_ENTRIES = gct_pkg::MAX_ENTRIES_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration write channel
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [gct_pkg::ID_W-1:0]  cfg_data_i,
  // input queue side
  input  logic                      push,
  output logic                      full,
  input  logic [1:0]                cmd_i,
  input  logic [gct_pkg::ID_W-1:0]  node_id_i,
  input  logic [gct_pkg::CNT_W-1:0] amount_i,
  // result queue side
  output logic                      empty,
  input  logic                      pop,
  output logic [gct_pkg::ID_W-1:0]  entry_node_o,
  output logic [gct_pkg::CNT_W-1:0] entry_count_o,
  output logic                      entry_valid_o,
  output logic                      last_o,
  output logic                      changed_o,
  output logic                      table_full_o,
  output logic [gct_pkg::CNT_W-1:0] total_o,
  output logic [gct_pkg::CNT_W-1:0] local_total_o
);

  gct_pkg::cmd_t    cmd;
  gct_pkg::q_stat_t stat;
  gct_pkg::res_t    res;
  logic             take;
  logic             res_valid;

  assign cfg_ready_o = 1'b1;

  // command intake and queue
  gct_front #(
    .DEPTH(gct_pkg::CMD_DEPTH)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push     (push),
    .full     (full),
    .cmd_i    (cmd_i),
    .node_id_i(node_id_i),
    .amount_i (amount_i),
    .cmd_o    (cmd),
    .stat_o   (stat),
    .take_i   (take)
  );

  // table and sequencer
  gct_back #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_valid_i && cfg_ready_o),
    .cfg_data_i (cfg_data_i),
    .cmd_i      (cmd),
    .stat_i     (stat),
    .take_o     (take),
    .res_o      (res),
    .res_valid_o(res_valid),
    .pop_i      (pop)
  );

  // result ports
  assign empty         = !res_valid;
  assign entry_node_o  = res.node;
  assign entry_count_o = res.count;
  assign entry_valid_o = res.valid;
  assign last_o        = res.last;
  assign changed_o     = res.changed;
  assign table_full_o  = res.full;
  assign total_o       = res.total;
  assign local_total_o = res.local_total;

endmodule

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for grow_only_counter_table_core
// depends on gct_pkg and the core; predicts every result from its own copy of the table
`timescale 1ns / 100ps

module tb_top;
  import gct_pkg::*;

  localparam int unsigned TABLE_SLOTS    = MAX_ENTRIES_DEF;
  localparam int          IDLE_GAP       = 48;    // longer than the slowest command
  localparam int          TAIL_CYCLES    = 80;
  localparam int          HOLD_CYCLES    = 200;   // long receiver hold-off
  localparam int          WATCHDOG_LIMIT = 3000;
  localparam int          MAX_PRINTS     = 30;
  localparam logic [CNT_W-1:0] CNT_MAX   = '1;

  // one command as offered on the input queue
  typedef struct {
    op_e             op;
    logic [ID_W-1:0]  nid;
    logic [CNT_W-1:0] amt;
  } cmd_item_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [ID_W-1:0]  cfg_data_i  = '0;
  logic             push        = 1'b0;
  logic             full;
  logic [1:0]       cmd_i       = '0;
  logic [ID_W-1:0]  node_id_i   = '0;
  logic [CNT_W-1:0] amount_i    = '0;
  logic             empty;
  logic             pop         = 1'b0;
  logic [ID_W-1:0]  entry_node_o;
  logic [CNT_W-1:0] entry_count_o;
  logic             entry_valid_o;
  logic             last_o;
  logic             changed_o;
  logic             table_full_o;
  logic [CNT_W-1:0] total_o;
  logic [CNT_W-1:0] local_total_o;

  grow_only_counter_table_core #(
    .MAX_ENTRIES(TABLE_SLOTS)
  ) u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .cmd_i         (cmd_i),
    .node_id_i     (node_id_i),
    .amount_i      (amount_i),
    .empty         (empty),
    .pop           (pop),
    .entry_node_o  (entry_node_o),
    .entry_count_o (entry_count_o),
    .entry_valid_o (entry_valid_o),
    .last_o        (last_o),
    .changed_o     (changed_o),
    .table_full_o  (table_full_o),
    .total_o       (total_o),
    .local_total_o (local_total_o)
  );

  // clock
  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // shadow copy of the counter table
  logic [ID_W-1:0]  local_id;
  logic [ID_W-1:0]  id_tab  [TABLE_SLOTS];
  logic [CNT_W-1:0] cnt_tab [TABLE_SLOTS];
  int               fill;
  logic             dirty;
  logic [CNT_W-1:0] run_sum;

  cmd_item_t        cmd_pending[$];
  res_t             exp_results[$];
  logic [ID_W-1:0]  id_pool[$];

  logic in_taken  = 1'b0;
  logic cfg_taken = 1'b0;
  int   errors       = 0;
  int   cmds_done    = 0;
  int   results_done = 0;
  int   snap_results = 0;
  int   drops_seen   = 0;
  int   cfg_writes   = 0;
  int   hold_requests = 0;
  int   holds_served  = 0;
  res_t want_res;

  function automatic logic [ID_W-1:0] slot_node(input int i);
    return (i == 0) ? local_id : id_tab[i];
  endfunction

  // lowest slot holding the id, slot zero first; -1 when absent
  function automatic int find_slot(input logic [ID_W-1:0] id);
    int i;
    for (i = 0; i < fill; i++) begin
      if (slot_node(i) == id) return i;
    end
    return -1;
  endfunction

  task automatic report_error(input string msg);
    errors++;
    if (errors <= MAX_PRINTS) $display("tb: error: %s", msg);
  endtask

  task automatic check_field(input string name, input logic [CNT_W-1:0] got,
                             input logic [CNT_W-1:0] want);
    if (got !== want)
      report_error($sformatf("result %0d %s got %h want %h", results_done, name, got, want));
  endtask

  // expected results of one accepted command
  task automatic predict_counter_step(input cmd_item_t c);
    res_t r;
    int   s;
    int   i;
    r = '0;
    r.last = 1'b1;
    case (c.op)
      OP_INC: begin
        cnt_tab[0] = cnt_tab[0] + c.amt;
        run_sum    = run_sum + c.amt;
        dirty      = 1'b1;
        r.changed  = (c.amt != '0);
      end
      OP_MERGE: begin
        s = find_slot(c.nid);
        if (s >= 0) begin
          if (c.amt > cnt_tab[s]) begin
            run_sum    = run_sum + (c.amt - cnt_tab[s]);
            cnt_tab[s] = c.amt;
            r.changed  = 1'b1;
          end
        end else if (fill < TABLE_SLOTS) begin
          id_tab[fill]  = c.nid;
          cnt_tab[fill] = c.amt;
          fill++;
          run_sum   = run_sum + c.amt;
          r.changed = 1'b1;
        end else begin
          r.full = 1'b1;
          drops_seen++;
        end
      end
      OP_SNAP: begin
        for (i = 0; i < fill; i++) begin
          r             = '0;
          r.node        = slot_node(i);
          r.count       = cnt_tab[i];
          r.valid       = 1'b1;
          r.last        = (i == fill - 1);
          r.total       = run_sum;
          r.local_total = cnt_tab[0];
          exp_results   = {exp_results, r};
          snap_results++;
        end
      end
      default: begin
        if (dirty) begin
          dirty   = 1'b0;
          r.node  = local_id;
          r.count = cnt_tab[0];
          r.valid = 1'b1;
        end
      end
    endcase
    if (c.op != OP_SNAP) begin
      r.total       = run_sum;
      r.local_total = cnt_tab[0];
      exp_results   = {exp_results, r};
    end
  endtask

  // monitor: input, config and result transfers at the rising edge
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_taken  <= 1'b0;
      cfg_taken <= 1'b0;
    end else begin
      in_taken  <= push && !full;
      cfg_taken <= cfg_valid_i && cfg_ready_o;
      if (cfg_valid_i && cfg_ready_o) begin
        local_id = cfg_data_i;
        cfg_writes++;
      end
      if (push && !full) begin
        predict_counter_step('{op: op_e'(cmd_i), nid: node_id_i, amt: amount_i});
        cmds_done++;
      end
      if (pop && !empty) begin
        if (exp_results.size() == 0) begin
          report_error($sformatf("result %0d arrived with nothing expected", results_done));
        end else begin
          want_res = exp_results.pop_front();
          check_field("entry_node", CNT_W'(entry_node_o), CNT_W'(want_res.node));
          check_field("entry_count", entry_count_o, want_res.count);
          check_field("entry_valid", CNT_W'(entry_valid_o), CNT_W'(want_res.valid));
          check_field("last", CNT_W'(last_o), CNT_W'(want_res.last));
          check_field("changed", CNT_W'(changed_o), CNT_W'(want_res.changed));
          check_field("table_full", CNT_W'(table_full_o), CNT_W'(want_res.full));
          check_field("total", total_o, want_res.total);
          check_field("local_total", local_total_o, want_res.local_total);
        end
        results_done++;
      end
    end
  end

  // driver: offers pending commands in bursts with random gaps
  int burst_left = 1;
  int gap_left   = 0;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      push <= 1'b0;
    end else begin
      if (in_taken) void'(cmd_pending.pop_front());
      if (push && !in_taken) begin
        // offer still waiting for its transfer
      end else if (gap_left > 0) begin
        gap_left--;
        push <= 1'b0;
      end else if (cmd_pending.size() > 0) begin
        cmd_i     <= cmd_pending[0].op;
        node_id_i <= cmd_pending[0].nid;
        amount_i  <= cmd_pending[0].amt;
        push      <= 1'b1;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 16);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        push <= 1'b0;
      end
    end
  end

  // receiver: random stall patterns, plus long hold-offs
  int         hold_left = 0;
  int         rx_phase  = 0;
  int         rx_mode   = 0;
  logic [7:0] rx_mask   = 8'hff;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      pop <= 1'b0;
    end else if (holds_served != hold_requests) begin
      holds_served++;
      hold_left = HOLD_CYCLES - 1;
      pop <= 1'b0;
    end else begin
      rx_phase++;
      if (rx_phase % 48 == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_mask = 8'($urandom);
      end
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= ($urandom_range(0, 3) == 0);
        default: pop <= rx_mask[rx_phase % 8];
      endcase
    end
  end

  // watchdog: cycles without any transfer
  int quiet = 0;

  initial begin
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((push && !full) || (pop && !empty) || (cfg_valid_i && cfg_ready_o)) quiet = 0;
      else quiet++;
    end
    $display("tb: no transfer for %0d cycles, giving up", quiet);
    $display("tb: failure");
    $finish;
  end

  task automatic queue_cmd(input op_e op, input logic [ID_W-1:0] nid,
                           input logic [CNT_W-1:0] amt);
    cmd_item_t c;
    c           = '{op: op, nid: nid, amt: amt};
    cmd_pending = {cmd_pending, c};
  endtask

  // wait for every command and result to drain, then let the core settle
  task automatic settle(input int cycles);
    while (cmd_pending.size() != 0 || push || exp_results.size() != 0) @(negedge clk_i);
    repeat (cycles) @(negedge clk_i);
  endtask

  task automatic write_local_id(input logic [ID_W-1:0] id);
    @(negedge clk_i);
    cfg_data_i  <= id;
    cfg_valid_i <= 1'b1;
    @(negedge clk_i);
    while (!cfg_taken) @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // random commands; new_pct is the share of merges that bring an unknown id
  task automatic queue_random(input int n, input int new_pct);
    int               k;
    int               roll;
    int               kind;
    int               s;
    logic [ID_W-1:0]  nid;
    logic [CNT_W-1:0] base;
    logic [CNT_W-1:0] amt;
    for (k = 0; k < n; k++) begin
      roll = $urandom_range(0, 99);
      kind = $urandom_range(0, 9);
      if (roll < 30) begin
        case (kind)
          0, 1:       amt = CNT_W'($urandom_range(0, 3));
          2, 3, 4, 5: amt = CNT_W'($urandom);
          6, 7:       amt = {$urandom, $urandom};
          8:          amt = CNT_MAX - CNT_W'($urandom_range(0, 3));
          default:    amt = 64'd1 << $urandom_range(0, 63);
        endcase
        queue_cmd(OP_INC, ID_W'($urandom), amt);
      end else if (roll < 75) begin
        if ($urandom_range(0, 99) < new_pct) begin
          nid     = ID_W'($urandom);
          id_pool = {id_pool, nid};
        end else if ($urandom_range(0, 6) == 0) begin
          nid = local_id;
        end else begin
          nid = id_pool[$urandom_range(0, id_pool.size() - 1)];
        end
        // aim near the count the table holds now so both outcomes occur
        s    = find_slot(nid);
        base = (s >= 0) ? cnt_tab[s] : {$urandom, $urandom};
        case (kind)
          0, 1, 2: amt = base - CNT_W'($urandom_range(0, 3));
          3, 4, 5: amt = base + CNT_W'($urandom_range(0, 3));
          6, 7:    amt = {$urandom, $urandom};
          8:       amt = '0;
          default: amt = CNT_MAX;
        endcase
        queue_cmd(OP_MERGE, nid, amt);
      end else if (roll < 88) begin
        queue_cmd(OP_SNAP, ID_W'($urandom), {$urandom, $urandom});
      end else begin
        queue_cmd(OP_DELTA, ID_W'($urandom), {$urandom, $urandom});
      end
    end
  endtask

  // stimulus sequence
  initial begin
    local_id = '0;
    id_tab   = '{default: '0};
    cnt_tab  = '{default: '0};
    fill     = 1;
    dirty    = 1'b0;
    run_sum  = '0;

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: increments, wrap, merges into local and new slots, snapshots, deltas
    write_local_id(16'h0000);
    queue_cmd(OP_INC, 16'h0000, 64'd0);
    queue_cmd(OP_DELTA, 16'h0000, 64'd0);
    queue_cmd(OP_DELTA, 16'hffff, CNT_MAX);
    queue_cmd(OP_SNAP, 16'h0000, 64'd0);
    queue_cmd(OP_INC, 16'h0000, 64'd1);
    queue_cmd(OP_INC, 16'hffff, CNT_MAX);
    queue_cmd(OP_INC, 16'h0000, 64'd5);
    queue_cmd(OP_MERGE, 16'h0000, 64'd100);
    queue_cmd(OP_MERGE, 16'h0000, 64'd3);
    queue_cmd(OP_MERGE, 16'h1234, 64'd7);
    queue_cmd(OP_MERGE, 16'h1234, 64'd7);
    queue_cmd(OP_MERGE, 16'hffff, CNT_MAX);
    queue_cmd(OP_MERGE, 16'h1234, 64'd8);
    queue_cmd(OP_MERGE, 16'h0001, 64'd0);
    queue_cmd(OP_SNAP, 16'h0000, 64'd0);
    queue_cmd(OP_DELTA, 16'h0000, 64'd0);
    queue_cmd(OP_DELTA, 16'h0000, 64'd0);
    settle(IDLE_GAP);

    // local id now duplicates a remote slot: slot zero must win
    write_local_id(16'h1234);
    queue_cmd(OP_MERGE, 16'h1234, 64'd500);
    queue_cmd(OP_SNAP, 16'h0000, 64'd0);
    queue_cmd(OP_INC, 16'h0000, 64'd1);
    queue_cmd(OP_DELTA, 16'h0000, 64'd0);
    settle(IDLE_GAP);

    write_local_id(16'hffff);
    queue_cmd(OP_MERGE, 16'hffff, CNT_MAX - 1);
    queue_cmd(OP_SNAP, 16'h0000, 64'd0);
    queue_cmd(OP_DELTA, 16'h0000, 64'd0);
    settle(IDLE_GAP);

    id_pool = '{16'h0000, 16'h0001, 16'h1234, 16'hffff};

    // random phases with different local ids
    write_local_id(ID_W'($urandom));
    queue_random(60, 12);
    settle(IDLE_GAP);

    // receiver holds off while the sender keeps offering
    write_local_id(id_pool[$urandom_range(0, id_pool.size() - 1)]);
    hold_requests++;
    queue_random(60, 12);
    settle(IDLE_GAP);

    write_local_id(16'h0000);
    queue_random(60, 12);
    settle(IDLE_GAP);

    // more unknown ids so the table runs out of slots
    write_local_id(16'hffff);
    queue_random(60, 40);
    settle(IDLE_GAP);

    write_local_id(ID_W'($urandom));
    hold_requests++;
    queue_random(60, 12);
    settle(TAIL_CYCLES);

    if (exp_results.size() != 0)
      report_error($sformatf("%0d expected results never arrived", exp_results.size()));

    $display("tb: %0d commands, %0d results checked, %0d snapshot entries",
             cmds_done, results_done, snap_results);
    $display("tb: %0d local id writes, %0d merges dropped on a full table, %0d errors",
             cfg_writes, drops_seen, errors);
    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

@@ grow_only_counter_table_core.f @@
hdl/gct_pkg.sv
hdl/gct_ram.sv
hdl/gct_front.sv
hdl/gct_back.sv
hdl/grow_only_counter_table_core.sv
bench/tb_top.sv
